// ----- hw/rtl/v27ter_tx_symbol_mapper_macros.svh -----
// Assertion macros for the V.27ter transmit symbol mapper.
// Included by files that check their own logic; no other dependencies.
`ifndef V27TER_TX_SYMBOL_MAPPER_MACROS_SVH
`define V27TER_TX_SYMBOL_MAPPER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define V27TX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("v27tx assertion failed");
// Next-cycle implication, checked out of reset.
`define V27TX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("v27tx assertion failed");
`else
`define V27TX_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define V27TX_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/v27tx_pkg.sv -----
// Shared types, constants and scrambler functions for the V.27ter symbol mapper.
// No dependencies; used by v27tx_symbol_logic and the top level.
`timescale 1ns / 1ps
`default_nettype none

package v27tx_pkg;

    localparam logic [11:0] SCR_SEED      = 12'h03C;
    localparam logic [5:0]  GUARD_LIMIT   = 6'd33;
    localparam logic [10:0] STEP_START    = 11'd320;
    localparam logic [10:0] LEN_SILENT    = 11'd32;
    localparam logic [10:0] LEN_REVERSAL  = 11'd50;
    localparam logic [10:0] LEN_SCRAMBLED = 11'd1074;
    localparam logic [10:0] LEN_ONES      = 11'd8;
    localparam logic [10:0] STEP_MAX      = 11'd2047;
    localparam logic [10:0] END_SILENT    = STEP_START + LEN_SILENT;
    localparam logic [10:0] END_REVERSAL  = END_SILENT + LEN_REVERSAL;
    localparam logic [10:0] END_SCRAMBLED = END_REVERSAL + LEN_SCRAMBLED;
    localparam logic [10:0] END_TRAIN     = END_SCRAMBLED + LEN_ONES;
    localparam logic [10:0] DATA_START    = END_TRAIN + 11'd1;
    localparam logic [10:0] END_SHUTDOWN  = END_TRAIN + 11'd32;

    // Phase steps in 45 degree units
    localparam logic [2:0] STEPS_TRIBIT [8] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd6, 3'd7, 3'd5, 3'd4};
    localparam logic [2:0] STEPS_DIBIT  [4] = '{3'd0, 3'd2, 3'd6, 3'd4};
    localparam logic [2:0] PHASE_REVERSAL = 3'd4;

    // Request operation codes
    localparam logic OP_SYMBOL  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // rate_mode codes
    localparam logic RATE_2400 = 1'b0;
    localparam logic RATE_4800 = 1'b1;

    // Register word index (paddr[2])
    localparam logic REG_RATE_MODE = 1'b0;
    localparam logic RATE_MODE_RESET = RATE_4800;

    typedef struct packed {
        logic [11:0] shift;
        logic [5:0]  guard;
        logic        train;
        logic [10:0] step;
        logic [2:0]  phase;
    } t_state;

    typedef struct packed {
        logic [2:0] phase_index;
        logic       silent;
        logic [1:0] bits_taken;
        logic       done_res;
    } t_result;

    // Running state of the bit chain inside one symbol
    typedef struct packed {
        logic [11:0] shift;
        logic [5:0]  guard;
        logic        train;
        logic [1:0]  taken;
        logic        sbit;
    } t_bit_st;

    localparam t_state RESET_STATE = '{
        shift: SCR_SEED, guard: 6'd0, train: 1'b1, step: STEP_START, phase: 3'd0
    };

    // One self-synchronizing scrambler step with the repeat guard
    function automatic t_bit_st scramble(input t_bit_st st, input logic din);
        t_bit_st r;
        logic    o;
        r = st;
        o = din ^ st.shift[5] ^ st.shift[6];
        if (st.guard >= GUARD_LIMIT) begin
            o = ~o;
            r.guard = 6'd0;
        end else if ((st.shift[7] ^ o) & (st.shift[8] ^ o) & (st.shift[11] ^ o)) begin
            r.guard = 6'd0;
        end else begin
            r.guard = st.guard + 6'd1;
        end
        r.shift = {st.shift[10:0], o};
        r.sbit  = o;
        return r;
    endfunction

    // Take a user bit if available, else fall back to ones and re-enter training
    function automatic t_bit_st next_bit(input t_bit_st st, input logic [2:0] data,
                                         input logic [1:0] avail);
        t_bit_st r;
        logic    b;
        r = st;
        b = 1'b1;
        if (!st.train) begin
            if (st.taken < avail) begin
                b = data[st.taken];
                r.taken = st.taken + 2'd1;
            end else begin
                r.train = 1'b1;
            end
        end
        return scramble(r, b);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/v27tx_symbol_logic.sv -----
// Combinational next-state and result logic for one symbol request.
// Depends on v27tx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module v27tx_symbol_logic (
    input  var v27tx_pkg::t_state  i_state,
    input  wire logic              i_rate,
    input  wire logic [2:0]        i_data_bits,
    input  wire logic [1:0]        i_bits_available,
    output v27tx_pkg::t_state      o_state,
    output v27tx_pkg::t_result     o_result
);

    logic [10:0]        step_inc;
    logic               in_train_seg;
    logic               data_train;
    logic               done_flag;
    v27tx_pkg::t_bit_st tr0, tr1, tr2, tr3;
    v27tx_pkg::t_bit_st d0, d1, d2, d3, dfin;
    logic [2:0]         step_val;

    always_comb begin
        step_inc = (i_state.step < v27tx_pkg::STEP_MAX) ? i_state.step + 11'd1 : i_state.step;
        in_train_seg = i_state.train && (step_inc <= v27tx_pkg::END_SCRAMBLED);
        data_train   = i_state.train && (step_inc != v27tx_pkg::DATA_START);
        done_flag    = i_state.train && (step_inc >= v27tx_pkg::END_SHUTDOWN);

        // Scrambled reversal: three scrambled ones, the first sets the phase
        tr0 = '{shift: i_state.shift, guard: i_state.guard, train: 1'b1,
                taken: 2'd0, sbit: 1'b0};
        tr1 = v27tx_pkg::scramble(tr0, 1'b1);
        tr2 = v27tx_pkg::scramble(tr1, 1'b1);
        tr3 = v27tx_pkg::scramble(tr2, 1'b1);

        // Data symbol: first bit is the MSB of the step index
        d0 = '{shift: i_state.shift, guard: i_state.guard, train: data_train,
               taken: 2'd0, sbit: 1'b0};
        d1 = v27tx_pkg::next_bit(d0, i_data_bits, i_bits_available);
        d2 = v27tx_pkg::next_bit(d1, i_data_bits, i_bits_available);
        d3 = v27tx_pkg::next_bit(d2, i_data_bits, i_bits_available);
        if (i_rate == v27tx_pkg::RATE_4800) begin
            step_val = v27tx_pkg::STEPS_TRIBIT[{d1.sbit, d2.sbit, d3.sbit}];
            dfin     = d3;
        end else begin
            step_val = v27tx_pkg::STEPS_DIBIT[{d1.sbit, d2.sbit}];
            dfin     = d2;
        end

        o_state  = i_state;
        o_result = '0;
        if (i_state.train) begin
            o_state.step = step_inc;
        end
        if (in_train_seg) begin
            if (step_inc <= v27tx_pkg::END_SILENT) begin
                o_result.silent = 1'b1;
            end else if (step_inc <= v27tx_pkg::END_REVERSAL) begin
                o_state.phase = i_state.phase + v27tx_pkg::PHASE_REVERSAL;
            end else begin
                o_state.phase = i_state.phase + {tr1.sbit, 2'b00};
                o_state.shift = tr3.shift;
                o_state.guard = tr3.guard;
            end
            o_result.phase_index = o_result.silent ? 3'd0 : o_state.phase;
        end else begin
            o_state.shift = dfin.shift;
            o_state.guard = dfin.guard;
            o_state.train = dfin.train;
            o_state.phase = i_state.phase + step_val;
            o_result.phase_index = o_state.phase;
            o_result.bits_taken  = dfin.taken;
            o_result.done_res    = done_flag;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/v27ter_tx_symbol_mapper.sv -----
// V.27ter transmit symbol mapper: a request passes through the input register, then the result
// register; throughput one request per cycle while the result side does not stall.
// A restart request takes one slot and yields no result.
// The state update path is the scrambler chain of three bits in v27tx_symbol_logic.
// Synchronous active-low reset: training restarts, rate_mode returns to 4800 bit/s.
// Depends on v27tx_pkg, v27tx_symbol_logic and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "v27ter_tx_symbol_mapper_macros.svh"

module v27ter_tx_symbol_mapper (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_operation,
    input  wire logic [2:0]  i_data_bits,
    input  wire logic [1:0]  i_bits_available,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_phase_index,
    output logic             o_silent,
    output logic [1:0]       o_bits_taken,
    output logic             o_done_res,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Input register stage
    logic                r_in_valid;
    logic                r_op;
    logic [2:0]          r_data;
    logic [1:0]          r_avail;

    // Mapper state and configuration
    v27tx_pkg::t_state   r_state;
    v27tx_pkg::t_state   n_state;
    logic                r_rate;

    // Result register stage
    logic                r_out_valid;
    v27tx_pkg::t_result  r_result;
    v27tx_pkg::t_result  n_result;

    logic                w_restart;
    logic                w_adv;
    logic                w_cfg_wr;

    // The request in the input register moves on when the result slot is free
    // or is being emptied; a restart never needs the slot.
    assign w_restart = (r_op == v27tx_pkg::OP_RESTART);
    assign w_adv     = r_in_valid && (w_restart || !r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_adv;

    v27tx_symbol_logic u_logic (
        .i_state          (r_state),
        .i_rate           (r_rate),
        .i_data_bits      (r_data),
        .i_bits_available (r_avail),
        .o_state          (n_state),
        .o_result         (n_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op    <= i_operation;
            r_data  <= i_data_bits;
            r_avail <= i_bits_available;
        end
    end

    // State update, in request order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= v27tx_pkg::RESET_STATE;
        end else if (w_adv) begin
            r_state <= w_restart ? v27tx_pkg::RESET_STATE : n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && !w_restart) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && !w_restart) begin
            r_result <= n_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_phase_index = r_result.phase_index;
    assign o_silent      = r_result.silent;
    assign o_bits_taken  = r_result.bits_taken;
    assign o_done_res    = r_result.done_res;

    // Configuration port: one register at word 0, byte lanes ignored
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= v27tx_pkg::RATE_MODE_RESET;
        end else if (w_cfg_wr && (paddr[2] == v27tx_pkg::REG_RATE_MODE)) begin
            r_rate <= pwdata[0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            v27tx_pkg::REG_RATE_MODE: prdata = {31'd0, r_rate};
            default:                  prdata = 32'd0;
        endcase
    end

    // Checks
    `V27TX_ASSERT_NOW(a_silent_clean, i_clk, i_rst_n, o_valid && o_silent,
        (o_phase_index == 3'd0) && (o_bits_taken == 2'd0) && !o_done_res)
    `V27TX_ASSERT_NOW(a_guard_bound, i_clk, i_rst_n, 1'b1,
        r_state.guard <= v27tx_pkg::GUARD_LIMIT)
    `V27TX_ASSERT_NEXT(a_restart_state, i_clk, i_rst_n, w_adv && w_restart,
        r_state == v27tx_pkg::RESET_STATE)
    `V27TX_ASSERT_NEXT(a_step_monotonic, i_clk, i_rst_n, w_adv && !w_restart,
        r_state.step >= $past(r_state.step))
    `V27TX_ASSERT_NOW(a_done_in_train, i_clk, i_rst_n, o_valid && o_done_res, r_state.train)

endmodule

`default_nettype wire

// ----- tb/tb_v27ter_tx_symbol_mapper.sv -----
// Testbench for v27ter_tx_symbol_mapper: drives symbol requests and checks each
// result against a cycle-free predictor of the scrambler, training and phase state.
// Depends on v27tx_pkg (result struct, codes, register index) and the mapper RTL.
`timescale 1ns / 1ps

module tb_v27ter_tx_symbol_mapper;

    // Training schedule, counted in symbol_step values
    localparam logic [11:0] SCR_INIT       = 12'h03C;
    localparam logic [5:0]  GUARD_MAX      = 6'd33;
    localparam logic [10:0] STEP_INIT      = 11'd320;
    localparam logic [10:0] STEP_TOP       = 11'd2047;
    localparam logic [10:0] LAST_SILENT    = STEP_INIT + 11'd32;
    localparam logic [10:0] LAST_REVERSAL  = LAST_SILENT + 11'd50;
    localparam logic [10:0] LAST_SCRAMBLED = LAST_REVERSAL + 11'd1074;
    localparam logic [10:0] LAST_ONES      = LAST_SCRAMBLED + 11'd8;
    localparam logic [10:0] DONE_STEP      = LAST_ONES + 11'd32;
    // symbols after a restart before the first one that carries user bits
    localparam int unsigned TRAIN_SYMBOLS  = LAST_ONES - STEP_INIT;

    // Phase steps in 45 degree units, indexed by the scrambled bit group
    localparam logic [2:0] GRAY_TRIBIT [8] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd6, 3'd7, 3'd5, 3'd4};
    localparam logic [2:0] STEP_DIBIT  [4] = '{3'd0, 3'd2, 3'd6, 3'd4};

    localparam logic [2:0]  RATE_ADDR   = {v27tx_pkg::REG_RATE_MODE, 2'b00};
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_ready;
    logic        i_operation      = 1'b0;
    logic [2:0]  i_data_bits      = 3'd0;
    logic [1:0]  i_bits_available = 2'd0;
    logic        o_valid;
    logic        i_ready          = 1'b0;
    logic [2:0]  o_phase_index;
    logic        o_silent;
    logic [1:0]  o_bits_taken;
    logic        o_done_res;
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [2:0]  paddr            = 3'd0;
    logic [31:0] pwdata           = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    v27ter_tx_symbol_mapper uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_data_bits      (i_data_bits),
        .i_bits_available (i_bits_available),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_phase_index    (o_phase_index),
        .o_silent         (o_silent),
        .o_bits_taken     (o_bits_taken),
        .o_done_res       (o_done_res),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Predictor state: mirrors the mapper's registers
    logic        rate_sel;
    logic [11:0] scr_reg;
    logic [5:0]  guard_cnt;
    logic        train_on;
    logic [10:0] step_cnt;
    logic [2:0]  phase_acc;

    v27tx_pkg::t_result expected_symbols[$];

    int unsigned n_errors    = 0;
    int unsigned n_checked   = 0;
    int unsigned n_user      = 0;
    int unsigned n_done      = 0;
    int unsigned n_restarts  = 0;
    int unsigned cycle_count = 0;

    // Idle shaping: "calm" modes give stretches with no gaps at all
    bit          tx_calm     = 1'b0;
    bit          rx_calm     = 1'b0;
    logic        rx_hold_req = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned stall_left  = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_symbols.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void restart_model();
        scr_reg   = SCR_INIT;
        guard_cnt = 6'd0;
        train_on  = 1'b1;
        step_cnt  = STEP_INIT;
        phase_acc = 3'd0;
    endfunction

    // One scrambler bit: taps 6 and 7 (1-based), plus the guard that inverts
    // the output after 33 bits in a row that repeat an 8/9/12-bit-old pattern.
    function automatic logic scramble_bit(input logic din);
        logic sbit;
        sbit = din ^ scr_reg[5] ^ scr_reg[6];
        if (guard_cnt >= GUARD_MAX) begin
            sbit      = ~sbit;
            guard_cnt = 6'd0;
        end else if ((scr_reg[7] ^ sbit) & (scr_reg[8] ^ sbit) & (scr_reg[11] ^ sbit)) begin
            guard_cnt = 6'd0;
        end else begin
            guard_cnt = guard_cnt + 6'd1;
        end
        scr_reg = {scr_reg[10:0], sbit};
        return sbit;
    endfunction

    // Next user bit if one is left, else a one; running short drops back
    // into training so the step counter resumes toward shutdown.
    function automatic logic draw_bit(input logic [2:0] data, input logic [1:0] avail,
                                      inout logic [1:0] taken);
        logic b;
        b = 1'b1;
        if (!train_on) begin
            if (taken < avail) begin
                b     = data[taken];
                taken = taken + 2'd1;
            end else begin
                train_on = 1'b1;
            end
        end
        return scramble_bit(b);
    endfunction

    // Advances the model by one request; returns 1 when a symbol comes out
    function automatic logic map_symbol(input logic op, input logic [2:0] data,
                                        input logic [1:0] avail,
                                        output v27tx_pkg::t_result sym);
        logic [2:0] code;
        logic [1:0] taken;
        sym   = '0;
        code  = 3'd0;
        taken = 2'd0;
        if (op == v27tx_pkg::OP_RESTART) begin
            restart_model();
            return 1'b0;
        end
        if (train_on) begin
            if (step_cnt < STEP_TOP)
                step_cnt = step_cnt + 11'd1;
            if (step_cnt <= LAST_SCRAMBLED) begin
                if (step_cnt <= LAST_SILENT) begin
                    sym.silent = 1'b1;
                end else if (step_cnt <= LAST_REVERSAL) begin
                    phase_acc = phase_acc + 3'd4;
                end else begin
                    // every third scrambled bit picks 0 or 180 degrees
                    code[2] = scramble_bit(1'b1);
                    void'(scramble_bit(1'b1));
                    void'(scramble_bit(1'b1));
                    phase_acc = phase_acc + code;
                end
                sym.phase_index = sym.silent ? 3'd0 : phase_acc;
                return 1'b1;
            end
            if (step_cnt == LAST_ONES + 11'd1)
                train_on = 1'b0;
            if (step_cnt >= DONE_STEP)
                sym.done_res = 1'b1;
        end
        if (rate_sel == v27tx_pkg::RATE_4800) begin
            code[2]   = draw_bit(data, avail, taken);
            code[1]   = draw_bit(data, avail, taken);
            code[0]   = draw_bit(data, avail, taken);
            phase_acc = phase_acc + GRAY_TRIBIT[code];
        end else begin
            code[1]   = draw_bit(data, avail, taken);
            code[0]   = draw_bit(data, avail, taken);
            phase_acc = phase_acc + STEP_DIBIT[code[1:0]];
        end
        sym.phase_index = phase_acc;
        sym.bits_taken  = taken;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- handshakes

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one request and predicts its symbol once it is accepted. Valid
    // stays high on return so the next request can follow without a gap.
    task automatic send_symbol(input logic op, input logic [2:0] data,
                               input logic [1:0] avail);
        int unsigned        gap;
        v27tx_pkg::t_result sym;
        gap = pick_gap(tx_calm);
        if ($urandom_range(0, 299) == 0)
            tx_calm = ~tx_calm;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_operation      <= op;
        i_data_bits      <= data;
        i_bits_available <= avail;
        do @(posedge i_clk); while (!o_ready);
        if (op == v27tx_pkg::OP_RESTART)
            n_restarts++;
        if (map_symbol(op, data, avail, sym)) begin
            expected_symbols.push_back(sym);
            if (sym.bits_taken != 2'd0)
                n_user++;
            if (sym.done_res)
                n_done++;
        end
    endtask

    // Drops valid and waits until every predicted symbol has come back;
    // a trailing restart has no result, so give the pipeline time to settle.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_symbols.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_rate_readback(input logic want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= RATE_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {31'd0, want}) begin
            n_errors++;
            $error("rate_mode readback: expected %0h, got %0h", {31'd0, want}, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Rate writes only happen with the block idle
    task automatic set_rate(input logic rate);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RATE_ADDR;
        pwdata  <= {31'd0, rate};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rate_sel = rate;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        check_rate_readback(rate);
    endtask

    // Training symbols ignore the data fields, so fill them at random
    task automatic send_training(input int unsigned count);
        repeat (count)
            send_symbol(v27tx_pkg::OP_SYMBOL, 3'($urandom_range(0, 7)),
                        2'($urandom_range(0, 3)));
    endtask

    // User data with enough bits for the current rate
    task automatic send_data(input int unsigned count);
        logic [1:0] avail;
        repeat (count) begin
            avail = (rate_sel == v27tx_pkg::RATE_4800) ? 2'd3 : 2'($urandom_range(2, 3));
            send_symbol(v27tx_pkg::OP_SYMBOL, 3'($urandom_range(0, 7)), avail);
        end
    endtask

    // ---------------------------------------------------------------- checker

    task automatic check_symbol();
        v27tx_pkg::t_result want;
        if (expected_symbols.size() == 0) begin
            n_errors++;
            $error("symbol with no request pending: phase_index %0d silent %0d",
                   o_phase_index, o_silent);
        end else begin
            want = expected_symbols.pop_front();
            n_checked++;
            if (o_phase_index !== want.phase_index) begin
                n_errors++;
                $error("phase_index: expected %0d, got %0d", want.phase_index, o_phase_index);
            end
            if (o_silent !== want.silent) begin
                n_errors++;
                $error("silent: expected %0d, got %0d", want.silent, o_silent);
            end
            if (o_bits_taken !== want.bits_taken) begin
                n_errors++;
                $error("bits_taken: expected %0d, got %0d", want.bits_taken, o_bits_taken);
            end
            if (o_done_res !== want.done_res) begin
                n_errors++;
                $error("done_res: expected %0d, got %0d", want.done_res, o_done_res);
            end
        end
    endtask

    // Result side: checks accepted symbols and throttles i_ready. A hold
    // request from a test parks ready low until hold_left runs down, so the block backs up.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                check_symbol();
            if ($urandom_range(0, 249) == 0)
                rx_calm = ~rx_calm;
            if (rx_hold_req) begin
                hold_left = HOLD_CYCLES;
                rx_hold_req <= 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                stall_left = pick_gap(rx_calm);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // Reset value of the rate register, silent opening symbols straight out of
    // reset with extreme field values, and restarts in the middle of silence.
    task automatic test_silent_preamble();
        check_rate_readback(v27tx_pkg::RATE_4800);
        send_symbol(v27tx_pkg::OP_SYMBOL, 3'd0, 2'd0);
        send_symbol(v27tx_pkg::OP_SYMBOL, 3'd7, 2'd3);
        send_symbol(v27tx_pkg::OP_SYMBOL, 3'd5, 2'd1);
        send_symbol(v27tx_pkg::OP_SYMBOL, 3'd2, 2'd2);
        send_symbol(v27tx_pkg::OP_RESTART, 3'd7, 2'd3);
        send_symbol(v27tx_pkg::OP_SYMBOL, 3'd0, 2'd0);
        send_symbol(v27tx_pkg::OP_SYMBOL, 3'd7, 2'd0);
        send_symbol(v27tx_pkg::OP_RESTART, 3'd0, 2'd0);
        send_training(14);
    endtask

    // Full 4800 sequence: training, tribits with extreme data, a long receiver
    // hold-off, a sender pause, a rate switch mid-stream, data running short
    // with two valid bits, then the ones padding past done.
    task automatic test_tribit_session();
        send_symbol(v27tx_pkg::OP_RESTART, 3'd3, 2'd1);
        send_training(300);
        rx_hold_req <= 1'b1;
        send_training(TRAIN_SYMBOLS - 300);
        send_symbol(v27tx_pkg::OP_SYMBOL, 3'd0, 2'd3);
        send_symbol(v27tx_pkg::OP_SYMBOL, 3'd7, 2'd3);
        send_data(40);
        drain_results();
        send_data(5);
        set_rate(v27tx_pkg::RATE_2400);
        send_data(20);
        set_rate(v27tx_pkg::RATE_4800);
        send_data(10);
        send_symbol(v27tx_pkg::OP_SYMBOL, 3'($urandom_range(0, 7)), 2'd2);
        send_training(45);
    endtask

    // 2400 sequence: dibits, data running short with one valid bit, then
    // enough ones for the step counter to pin at its top value.
    task automatic test_dibit_saturation();
        set_rate(v27tx_pkg::RATE_2400);
        send_symbol(v27tx_pkg::OP_RESTART, 3'd0, 2'd0);
        send_training(TRAIN_SYMBOLS);
        send_symbol(v27tx_pkg::OP_SYMBOL, 3'd0, 2'd2);
        send_symbol(v27tx_pkg::OP_SYMBOL, 3'd7, 2'd3);
        send_data(30);
        send_symbol(v27tx_pkg::OP_SYMBOL, 3'($urandom_range(0, 7)), 2'd1);
        send_training(STEP_TOP - LAST_ONES + 20);
    endtask

    // Sessions at a random rate. Most run into user data with the odd short
    // request or restart; some are cut off by a restart inside training.
    task automatic test_random_sessions();
        int unsigned run;
        int unsigned k;
        int unsigned roll;
        logic [1:0]  need;
        for (run = 0; run < 4; run++) begin
            set_rate(1'($urandom_range(0, 1)));
            need = (rate_sel == v27tx_pkg::RATE_4800) ? 2'd3 : 2'd2;
            send_symbol(v27tx_pkg::OP_RESTART, 3'($urandom_range(0, 7)),
                        2'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) == 0) begin
                send_training($urandom_range(1, TRAIN_SYMBOLS - 1));
            end else begin
                send_training(TRAIN_SYMBOLS);
                for (k = 0; k < $urandom_range(20, 120); k++) begin
                    roll = $urandom_range(0, 99);
                    if (roll == 0)
                        send_symbol(v27tx_pkg::OP_RESTART, 3'($urandom_range(0, 7)),
                                    2'($urandom_range(0, 3)));
                    else if (roll < 6)
                        send_symbol(v27tx_pkg::OP_SYMBOL, 3'($urandom_range(0, 7)),
                                    2'($urandom_range(0, need - 1)));
                    else
                        send_data(1);
                end
                send_training($urandom_range(0, 60));
            end
        end
    endtask

    initial begin
        rate_sel = v27tx_pkg::RATE_4800;
        restart_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_silent_preamble();
        test_tribit_session();
        test_dibit_saturation();
        test_random_sessions();
        drain_results();
        repeat (10) @(posedge i_clk);
        $display("Checked %0d symbols over %0d restarts at both rates:", n_checked, n_restarts);
        $display("  %0d carried user bits, %0d had done set", n_user, n_done);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
